/* rtl/avhv_pkg.sv */
// ----------------------------------------------------------------------------
// avhv_pkg
// Shared types and constants of the voxel albedo HSV variation block.
// ----------------------------------------------------------------------------
package avhv_pkg;

  // Register map, one 64-bit register every 8 bytes
  typedef enum logic [2:0] {
    REG_MASTER = 3'd0,
    REG_AMPS   = 3'd1,
    REG_HUE    = 3'd2,
    REG_SAT    = 3'd3,
    REG_VAL    = 3'd4,
    REG_FAM    = 3'd5
  } reg_idx_e;

  // Material categories with an amplitude
  localparam logic [2:0] CAT_GENERIC = 3'd0;
  localparam logic [2:0] CAT_GRAVEL  = 3'd1;
  localparam logic [2:0] CAT_PLANT   = 3'd2;
  localparam logic [2:0] CAT_STONE   = 3'd3;
  localparam logic [2:0] CAT_WOOD    = 3'd4;

  // Hash constants
  localparam logic [31:0] HASH_SEED  = 32'h9e3779b9;
  localparam logic [31:0] MUL_KEY    = 32'h85ebca6b;
  localparam logic [31:0] MUL_X      = 32'h8da6b343;
  localparam logic [31:0] MUL_Y      = 32'hd8163841;
  localparam logic [31:0] MUL_Z      = 32'hcb1ab31f;
  localparam logic [31:0] MUL_SALT   = 32'h27d4eb2d;
  localparam logic [31:0] MUL_AV1    = 32'h7feb352d;
  localparam logic [31:0] MUL_AV2    = 32'h846ca68b;
  localparam logic [31:0] KEY_COARSE = 32'h6a09e667;
  localparam logic [31:0] KEY_FINE   = 32'hbb67ae85;

  // Salt of each channel (hue, saturation, value) already multiplied in
  localparam logic [31:0] SALT_MIX [3] = '{
    32'(64'(32'h68bc21eb) * 64'(MUL_SALT)),
    32'(64'(32'h02e5be93) * 64'(MUL_SALT)),
    32'(64'(32'h967a889b) * 64'(MUL_SALT))
  };

  // Lerp weight of fine over coarse noise, 0.38 in Q16
  localparam logic signed [33:0] FAMILY_MIX = 34'sd24904;

  // Register stages of the front part
  localparam int unsigned FRONT_STAGES = 9;

  typedef struct packed {
    logic [15:0]        color_red;
    logic [15:0]        color_green;
    logic [15:0]        color_blue;
    logic [2:0]         category;
    logic signed [31:0] voxel_x;
    logic signed [31:0] voxel_y;
    logic signed [31:0] voxel_z;
    logic [31:0]        volume_key;
  } in_item_t;

  typedef struct packed {
    logic [14:0] out_red;
    logic [14:0] out_green;
    logic [14:0] out_blue;
  } out_item_t;

  // Configuration after clamping to the legal ranges
  typedef struct packed {
    logic [16:0] master;
    logic [59:0] amps;
    logic [14:0] hue_spread;
    logic [16:0] sat_spread;
    logic [16:0] val_spread;
    logic [16:0] fam_strength;
  } cfg_t;

  // Word handed from the noise front to the color back
  typedef struct packed {
    logic signed [18:0] term_hue;
    logic signed [18:0] term_sat;
    logic signed [18:0] term_val;
    logic [15:0]        red;
    logic [15:0]        green;
    logic [15:0]        blue;
    logic               bypass;
  } fb_word_t;

endpackage

/* rtl/voxel_albedo_hsv_variation.sv */
// ----------------------------------------------------------------------------
// voxel_albedo_hsv_variation
// Per-voxel albedo variation in HSV space driven by hashed cell noise.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                         payload
//  item      in         start & !busy                     item_i (in_item_t)
//  result    out        result_valid_o, one-cycle strobe  result_o (out_item_t)
//  config    in/out     APB write: psel&penable&pwrite    pwdata, 8-byte stride
//
//  One voxel is taken every cycle while busy is low. An accepted voxel passes
//  through 9 hash and noise stages, the queue and 23 back stages, most of
//  them set by the two 17-stage pipelined dividers of the RGB to HSV step.
//  busy stays low in normal use since the back drains the queue every cycle.
//  Reset clears the registers and the pipeline valid bits; results cannot
//  be stalled by the receiver.
// ----------------------------------------------------------------------------
module voxel_albedo_hsv_variation import avhv_pkg::*; #(
  parameter int unsigned COLOR_FRAC_BITS = 14,
  parameter int unsigned QUEUE_DEPTH     = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  in_item_t    item_i,
  output logic        result_valid_o,
  output out_item_t   result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);

  logic [16:0] master_q, sat_q, val_q, fam_q;
  logic [59:0] amps_q;
  logic [14:0] hue_q;
  logic        wr_en;
  cfg_t        cfg;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_q <= '0;
      amps_q   <= '0;
      hue_q    <= '0;
      sat_q    <= '0;
      val_q    <= '0;
      fam_q    <= '0;
    end else if (wr_en) begin
      unique case (reg_idx_e'(paddr[5:3]))
        REG_MASTER: master_q <= pwdata[16:0];
        REG_AMPS:   amps_q   <= pwdata[59:0];
        REG_HUE:    hue_q    <= pwdata[14:0];
        REG_SAT:    sat_q    <= pwdata[16:0];
        REG_VAL:    val_q    <= pwdata[16:0];
        REG_FAM:    fam_q    <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[5:3]))
      REG_MASTER: prdata = 64'(master_q);
      REG_AMPS:   prdata = 64'(amps_q);
      REG_HUE:    prdata = 64'(hue_q);
      REG_SAT:    prdata = 64'(sat_q);
      REG_VAL:    prdata = 64'(val_q);
      REG_FAM:    prdata = 64'(fam_q);
      default:    prdata = '0;
    endcase
  end

  // clamp to the legal ranges
  assign cfg.master       = (master_q > 17'd65536) ? 17'd65536 : master_q;
  assign cfg.amps         = amps_q;
  assign cfg.hue_spread   = (hue_q > 15'd16384) ? 15'd16384 : hue_q;
  assign cfg.sat_spread   = (sat_q > 17'd65536) ? 17'd65536 : sat_q;
  assign cfg.val_spread   = (val_q > 17'd65536) ? 17'd65536 : val_q;
  assign cfg.fam_strength = (fam_q > 17'd65536) ? 17'd65536 : fam_q;

  logic        accept, push, q_valid;
  fb_word_t    f_word, q_word;
  logic [AW:0] q_count;

  assign accept = start && !busy;
  // leave room for every word still in the front stages
  assign busy   = (32'(q_count) + FRONT_STAGES + 1) > QUEUE_DEPTH;

  avhv_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item_i),
    .cfg_i    (cfg),
    .push_o   (push),
    .word_o   (f_word)
  );

  avhv_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .word_i  (f_word),
    .valid_o (q_valid),
    .word_o  (q_word),
    .count_o (q_count)
  );

  avhv_back #(.COLOR_FRAC_BITS(COLOR_FRAC_BITS)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (q_valid),
    .word_i   (q_word),
    .valid_o  (result_valid_o),
    .result_o (result_o)
  );

endmodule

/* rtl/avhv_div.sv */
// ----------------------------------------------------------------------------
// avhv_div
// Pipelined restoring divider, one quotient bit per stage, with side data.
// ----------------------------------------------------------------------------
module avhv_div #(
  parameter int unsigned DW = 16,
  parameter int unsigned QW = 17,
  parameter int unsigned PW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [DW+QW-1:0] numer_i,
  input  logic [DW-1:0]    denom_i,
  input  logic [PW-1:0]    side_i,
  output logic             valid_o,
  output logic [QW-1:0]    quot_o,
  output logic [PW-1:0]    side_o
);

  // Numerator must stay below denom * 2^QW
  logic          vld_q  [0:QW];
  logic [DW-1:0] rem_q  [0:QW];
  logic [QW-1:0] low_q  [0:QW];
  logic [QW-1:0] quo_q  [0:QW];
  logic [DW-1:0] den_q  [0:QW];
  logic [PW-1:0] side_q [0:QW];

  assign vld_q[0]  = valid_i;
  assign rem_q[0]  = numer_i[DW+QW-1:QW];
  assign low_q[0]  = numer_i[QW-1:0];
  assign quo_q[0]  = '0;
  assign den_q[0]  = denom_i;
  assign side_q[0] = side_i;

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DW:0] trial;
    logic        fit;

    assign trial = {rem_q[i], low_q[i][QW-1-i]};
    assign fit   = trial >= {1'b0, den_q[i]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i+1]  <= fit ? DW'(trial - {1'b0, den_q[i]}) : trial[DW-1:0];
      low_q[i+1]  <= low_q[i];
      quo_q[i+1]  <= quo_q[i] | (QW'(fit) << (QW-1-i));
      den_q[i+1]  <= den_q[i];
      side_q[i+1] <= side_q[i];
    end
  end

  assign valid_o = vld_q[QW];
  assign quot_o  = quo_q[QW];
  assign side_o  = side_q[QW];

endmodule

/* rtl/avhv_front.sv */
// ----------------------------------------------------------------------------
// avhv_front
// Hashes the three cell levels, shapes the noise and scales the HSV offsets.
// ----------------------------------------------------------------------------
module avhv_front import avhv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  input  cfg_t     cfg_i,
  output logic     push_o,
  output fb_word_t word_o
);

  logic [FRONT_STAGES:1] vld_q;

  in_item_t           s1_q;
  logic [31:0]        h0_q   [3];
  logic [28:0]        mprod_q;
  logic [31:0]        m1_q   [3][3];
  logic [31:0]        m2_q   [3][3];
  logic signed [17:0] nq_q   [3][3];
  logic signed [17:0] own_q  [3];
  logic signed [18:0] blend_q [3];
  logic signed [18:0] paint_q [3];
  logic signed [20:0] t1_q   [3];
  logic signed [18:0] term_q [3];
  logic [16:0]        str_q  [3:FRONT_STAGES];
  logic [47:0]        rgb_q  [2:FRONT_STAGES];

  logic [31:0]        h0_d   [3];
  logic [28:0]        mprod_d;
  logic [16:0]        str_d;
  logic [31:0]        m1_d   [3][3];
  logic [31:0]        m2_d   [3][3];
  logic signed [17:0] nq_d   [3][3];
  logic signed [18:0] blend_d [3];
  logic signed [18:0] paint_d [3];
  logic signed [20:0] t1_d   [3];
  logic signed [18:0] term_d [3];

  function automatic logic signed [17:0] noise_q16(input logic [31:0] h);
    logic [40:0]        num;
    logic [16:0]        q0;
    logic [24:0]        rm;
    logic [17:0]        q;
    logic signed [18:0] n;
    // divide by 2^24-1: one correction step suffices
    num = {h[23:0], 17'd0} + 41'd8388607;
    q0  = num[40:24];
    rm  = {1'b0, num[23:0]} + {8'd0, q0};
    q   = {1'b0, q0} + ((rm >= 25'h0ffffff) ? 18'd1 : 18'd0);
    n   = $signed({1'b0, q}) - 19'sd65536;
    return n[17:0];
  endfunction

  // round magnitude to a multiple of 2^sh, half away from zero
  function automatic logic signed [17:0] quant(input logic signed [17:0] n,
                                               input logic coarse);
    logic [16:0] mag;
    logic [16:0] r;
    mag = n[17] ? 17'(-n) : 17'(n);
    if (coarse) begin
      r = ((mag + 17'd16384) >> 15) << 15;
    end else begin
      r = ((mag + 17'd8192) >> 14) << 14;
    end
    return n[17] ? -$signed({1'b0, r}) : $signed({1'b0, r});
  endfunction

  // stage 2: level seeds and strength product
  always_comb begin
    logic [31:0] cx, cy, cz, ck;
    logic [11:0] amp;
    for (int l = 0; l < 3; l++) begin
      unique case (l)
        1: begin
          cx = {{2{s1_q.voxel_x[31]}}, s1_q.voxel_x[31:2]};
          cy = {{2{s1_q.voxel_y[31]}}, s1_q.voxel_y[31:2]};
          cz = {{2{s1_q.voxel_z[31]}}, s1_q.voxel_z[31:2]};
          ck = s1_q.volume_key ^ KEY_COARSE;
        end
        2: begin
          cx = {s1_q.voxel_x[31], s1_q.voxel_x[31:1]};
          cy = {s1_q.voxel_y[31], s1_q.voxel_y[31:1]};
          cz = {s1_q.voxel_z[31], s1_q.voxel_z[31:1]};
          ck = s1_q.volume_key ^ KEY_FINE;
        end
        default: begin
          cx = s1_q.voxel_x;
          cy = s1_q.voxel_y;
          cz = s1_q.voxel_z;
          ck = s1_q.volume_key;
        end
      endcase
      h0_d[l] = HASH_SEED ^ (ck * MUL_KEY) ^ (cx * MUL_X) ^ (cy * MUL_Y) ^ (cz * MUL_Z);
    end
    case (s1_q.category)
      CAT_GENERIC: amp = cfg_i.amps[11:0];
      CAT_GRAVEL:  amp = cfg_i.amps[23:12];
      CAT_PLANT:   amp = cfg_i.amps[35:24];
      CAT_STONE:   amp = cfg_i.amps[47:36];
      CAT_WOOD:    amp = cfg_i.amps[59:48];
      default:     amp = 12'd0;
    endcase
    mprod_d = 29'(cfg_i.master) * 29'(amp);
  end

  // stage 3: first avalanche multiply, strength = (m*a + 2047) / 4095
  always_comb begin
    logic [29:0] sn;
    logic [17:0] ta;
    logic [6:0]  a2;
    logic [12:0] sr;
    logic [31:0] v;
    sn = {1'b0, mprod_q} + 30'd2047;
    ta = 18'(sn[29:12]) + 18'(sn[11:0]);
    a2 = ta[17:12];
    sr = 13'(a2) + 13'(ta[11:0]);
    str_d = 17'(sn[29:12]) + 17'(a2) + ((sr >= 13'd4095) ? 17'd1 : 17'd0);
    for (int l = 0; l < 3; l++) begin
      for (int s = 0; s < 3; s++) begin
        v = h0_q[l] ^ SALT_MIX[s];
        v = v ^ (v >> 16);
        m1_d[l][s] = v * MUL_AV1;
      end
    end
  end

  // stage 4: second avalanche multiply; stage 5: noise and quantize
  always_comb begin
    logic [31:0] v;
    logic signed [17:0] n;
    for (int l = 0; l < 3; l++) begin
      for (int s = 0; s < 3; s++) begin
        v = m1_q[l][s] ^ (m1_q[l][s] >> 15);
        m2_d[l][s] = v * MUL_AV2;
        v = m2_q[l][s] ^ (m2_q[l][s] >> 16);
        n = noise_q16(v);
        if (l == 0) begin
          nq_d[l][s] = n;
        end else begin
          nq_d[l][s] = quant(n, l == 1);
        end
      end
    end
  end

  // stages 6 to 9: blends and strength scaling
  always_comb begin
    logic signed [18:0] dfc;
    logic signed [33:0] pb;
    logic signed [19:0] dbo;
    logic signed [37:0] pp;
    logic signed [36:0] pt;
    logic signed [38:0] ps;
    logic [16:0]        sp;
    for (int s = 0; s < 3; s++) begin
      dfc = 19'(nq_q[2][s]) - 19'(nq_q[1][s]);
      pb  = 34'(dfc) * FAMILY_MIX;
      pb  = (pb + 34'sd32768) >>> 16;
      blend_d[s] = 19'(nq_q[1][s]) + pb[18:0];

      dbo = 20'(blend_q[s]) - 20'(own_q[s]);
      pp  = 38'(dbo) * $signed({21'd0, cfg_i.fam_strength});
      pp  = (pp + 38'sd32768) >>> 16;
      paint_d[s] = 19'(own_q[s]) + pp[18:0];

      case (s)
        0:       sp = {2'd0, cfg_i.hue_spread};
        1:       sp = cfg_i.sat_spread;
        default: sp = cfg_i.val_spread;
      endcase
      pt = 37'(paint_q[s]) * $signed({20'd0, sp});
      pt = (pt + 37'sd32768) >>> 16;
      t1_d[s] = pt[20:0];

      ps = 39'(t1_q[s]) * $signed({22'd0, str_q[8]});
      ps = (ps + 39'sd32768) >>> 16;
      term_d[s] = ps[18:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[FRONT_STAGES-1:1], accept_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_q <= item_i;
    end
    h0_q     <= h0_d;
    mprod_q  <= mprod_d;
    rgb_q[2] <= {s1_q.color_red, s1_q.color_green, s1_q.color_blue};
    for (int k = 3; k <= FRONT_STAGES; k++) begin
      rgb_q[k] <= rgb_q[k-1];
    end
    str_q[3] <= str_d;
    for (int k = 4; k <= FRONT_STAGES; k++) begin
      str_q[k] <= str_q[k-1];
    end
    m1_q <= m1_d;
    m2_q <= m2_d;
    nq_q <= nq_d;
    for (int s = 0; s < 3; s++) begin
      own_q[s] <= nq_q[0][s];
    end
    blend_q <= blend_d;
    paint_q <= paint_d;
    t1_q    <= t1_d;
    term_q  <= term_d;
  end

  assign push_o          = vld_q[FRONT_STAGES];
  assign word_o.term_hue = term_q[0];
  assign word_o.term_sat = term_q[1];
  assign word_o.term_val = term_q[2];
  assign word_o.red      = rgb_q[FRONT_STAGES][47:32];
  assign word_o.green    = rgb_q[FRONT_STAGES][31:16];
  assign word_o.blue     = rgb_q[FRONT_STAGES][15:0];
  assign word_o.bypass   = (str_q[FRONT_STAGES] == 17'd0);

endmodule

/* rtl/avhv_queue.sv */
// ----------------------------------------------------------------------------
// avhv_queue
// Small FIFO between the noise front and the color back.
// ----------------------------------------------------------------------------
module avhv_queue import avhv_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  fb_word_t                   word_i,
  output logic                       valid_o,
  output fb_word_t                   word_o,
  output logic [$clog2(DEPTH):0]     count_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  fb_word_t        mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [AW:0]     count_q;
  logic            pop;

  // back never stalls: drain whenever something is held
  assign pop = (count_q != '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + AW'(1);
      end
      if (push_i && !pop) begin
        count_q <= count_q + (AW+1)'(1);
      end else if (!push_i && pop) begin
        count_q <= count_q - (AW+1)'(1);
      end
    end
  end

  assign valid_o = pop;
  assign word_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

`ifndef SYNTHESIS
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < (AW+1)'(DEPTH) || pop))
    else $error("queue overflow");

  a_count_up : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop) |=> count_q == $past(count_q) + (AW+1)'(1))
    else $error("queue count did not advance on push");

  a_count_down : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!push_i && pop) |=> count_q == $past(count_q) - (AW+1)'(1))
    else $error("queue count did not drop on pop");
`endif

endmodule

/* rtl/avhv_back.sv */
// ----------------------------------------------------------------------------
// avhv_back
// RGB to HSV, applies the offsets, converts back to RGB and clamps; bypassed words keep their input color.
// ----------------------------------------------------------------------------
module avhv_back import avhv_pkg::*; #(
  parameter int unsigned COLOR_FRAC_BITS = 14
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  fb_word_t  word_i,
  output logic      valid_o,
  output out_item_t result_o
);

  localparam int unsigned Limit = ((135 << COLOR_FRAC_BITS) + 50) / 100;

  typedef struct packed {
    fb_word_t    w;
    logic [15:0] mx;
    logic        hz;
  } hside_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        bypass;
  } pass_t;

  function automatic logic [14:0] clamp_out(input logic signed [21:0] v);
    logic signed [23:0] vv;
    logic signed [23:0] lim;
    vv  = 24'(v);
    lim = $signed(24'(Limit));
    if (vv < 0) begin
      return 15'd0;
    end else if (vv > lim) begin
      return lim[14:0];
    end
    return vv[14:0];
  endfunction

  // b0: take word from the queue
  logic     v0_q;
  fb_word_t w0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    w0_q <= word_i;
  end

  // b1: max, min and divider operands
  logic [15:0] mx, mn, delta;
  logic [35:0] numer_h;
  logic [18:0] den_h;
  logic [32:0] numer_s;
  hside_t      hside_in;

  always_comb begin
    logic signed [20:0] num;
    mx = (w0_q.red > w0_q.green) ? w0_q.red : w0_q.green;
    if (w0_q.blue > mx) mx = w0_q.blue;
    mn = (w0_q.red < w0_q.green) ? w0_q.red : w0_q.green;
    if (w0_q.blue < mn) mn = w0_q.blue;
    delta = mx - mn;
    if (mx == w0_q.red) begin
      num = 21'(w0_q.green) - 21'(w0_q.blue);
      if (num < 0) num = num + 21'(delta) * 21'sd6;
    end else if (mx == w0_q.green) begin
      num = 21'(w0_q.blue) - 21'(w0_q.red) + 21'(delta) * 21'sd2;
    end else begin
      num = 21'(w0_q.red) - 21'(w0_q.green) + 21'(delta) * 21'sd4;
    end
    numer_h = {1'b0, num[18:0], 16'd0} + 36'(delta) * 36'd3;
    den_h   = 19'(delta) * 19'd6;
    numer_s = {1'b0, delta, 16'd0} + 33'(mx[15:1]);
    hside_in.w  = w0_q;
    hside_in.mx = mx;
    hside_in.hz = (delta == 16'd0);
  end

  logic        dv_h, dv_s;
  logic [16:0] q_h, q_s;
  hside_t      hside;
  logic        sz;

  avhv_div #(.DW(19), .QW(17), .PW($bits(hside_t))) u_div_hue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v0_q),
    .numer_i (numer_h),
    .denom_i (den_h),
    .side_i  (hside_in),
    .valid_o (dv_h),
    .quot_o  (q_h),
    .side_o  (hside)
  );

  avhv_div #(.DW(16), .QW(17), .PW(1)) u_div_sat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v0_q),
    .numer_i (numer_s),
    .denom_i (mx),
    .side_i  (mx == 16'd0),
    .valid_o (dv_s),
    .quot_o  (q_s),
    .side_o  (sz)
  );

  // b2: offsets applied
  logic               v2_q;
  logic [15:0]        hue2_q;
  logic signed [37:0] satp_q;
  logic signed [36:0] valp_q;
  pass_t              p2_q;

  // b3: rounded and clamped, hue split into sector and fraction
  logic               v3_q;
  logic [16:0]        sat3_q;
  logic [17:0]        val3_q;
  logic [2:0]         sec3_q;
  logic [15:0]        frac3_q;
  pass_t              p3_q;

  // b4, b5: partial products for p, q, t
  logic               v4_q, v5_q;
  logic [31:0]        x4_q;
  logic [32:0]        y4_q;
  logic [34:0]        pp4_q;
  logic [17:0]        val4_q, val5_q;
  logic [2:0]         sec4_q, sec5_q;
  pass_t              p4_q, p5_q;
  logic [49:0]        vx5_q;
  logic [50:0]        vy5_q;
  logic [17:0]        pc5_q;

  logic               v6_q;
  out_item_t          res_q;

  logic [15:0]        hue2_d;
  logic signed [37:0] satp_d;
  logic signed [36:0] valp_d;
  logic [16:0]        sat3_d;
  logic [17:0]        val3_d;
  logic [18:0]        hue6;
  logic [35:0]        ppr;
  out_item_t          res_d;

  always_comb begin
    logic [15:0]        hue;
    logic [16:0]        sat;
    logic signed [19:0] fs, fv;
    logic signed [37:0] sr;
    logic signed [36:0] vr;
    hue    = hside.hz ? 16'd0 : q_h[15:0];
    sat    = sz ? 17'd0 : q_s;
    hue2_d = 16'(hue + 16'(hside.w.term_hue));
    fs     = 20'sd65536 + 20'(hside.w.term_sat);
    fv     = 20'sd65536 + 20'(hside.w.term_val);
    satp_d = 38'($signed({1'b0, sat})) * 38'(fs);
    valp_d = 37'($signed({1'b0, hside.mx})) * 37'(fv);

    sr = (satp_q + 38'sd32768) >>> 16;
    if (sr < 0) begin
      sat3_d = 17'd0;
    end else if (sr > 38'sd65536) begin
      sat3_d = 17'd65536;
    end else begin
      sat3_d = sr[16:0];
    end
    vr = (valp_q + 37'sd32768) >>> 16;
    val3_d = (vr < 0) ? 18'd0 : vr[17:0];
    hue6   = 19'(hue2_q) * 19'd6;
    ppr    = {1'b0, pp4_q} + 36'd32768;
  end

  always_comb begin
    logic signed [52:0] tq, tt;
    logic signed [21:0] vq, vt, vp, vv;
    logic signed [21:0] rr, gg, bb;
    tq = $signed(53'd2147483648) - $signed({3'b0, vx5_q});
    tt = $signed(53'd2147483648) - $signed({2'b0, vy5_q});
    tq = tq >>> 32;
    tt = tt >>> 32;
    vv = $signed({4'b0, val5_q});
    vp = $signed({4'b0, pc5_q});
    vq = vv + tq[21:0];
    vt = vv + tt[21:0];
    case (sec5_q)
      3'd0:    begin rr = vv; gg = vt; bb = vp; end
      3'd1:    begin rr = vq; gg = vv; bb = vp; end
      3'd2:    begin rr = vp; gg = vv; bb = vt; end
      3'd3:    begin rr = vp; gg = vq; bb = vv; end
      3'd4:    begin rr = vt; gg = vp; bb = vv; end
      default: begin rr = vv; gg = vp; bb = vq; end
    endcase
    if (p5_q.bypass) begin
      rr = $signed({6'd0, p5_q.red});
      gg = $signed({6'd0, p5_q.green});
      bb = $signed({6'd0, p5_q.blue});
    end
    res_d.out_red   = clamp_out(rr);
    res_d.out_green = clamp_out(gg);
    res_d.out_blue  = clamp_out(bb);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v2_q <= dv_h && dv_s;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hue2_q <= hue2_d;
    satp_q <= satp_d;
    valp_q <= valp_d;
    p2_q   <= '{red: hside.w.red, green: hside.w.green, blue: hside.w.blue,
                bypass: hside.w.bypass};

    sat3_q  <= sat3_d;
    val3_q  <= val3_d;
    sec3_q  <= hue6[18:16];
    frac3_q <= hue6[15:0];
    p3_q    <= p2_q;

    x4_q   <= 32'(frac3_q) * 32'(sat3_q);
    y4_q   <= (33'd65536 - 33'(frac3_q)) * 33'(sat3_q);
    pp4_q  <= 35'(val3_q) * (35'd65536 - 35'(sat3_q));
    val4_q <= val3_q;
    sec4_q <= sec3_q;
    p4_q   <= p3_q;

    vx5_q  <= 50'(val4_q) * 50'(x4_q);
    vy5_q  <= 51'(val4_q) * 51'(y4_q);
    pc5_q  <= ppr[33:16];
    val5_q <= val4_q;
    sec5_q <= sec4_q;
    p5_q   <= p4_q;

    res_q <= res_d;
  end

  assign valid_o  = v6_q;
  assign result_o = res_q;

endmodule

/* tb/voxel_albedo_hsv_variation_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_albedo_hsv_variation_tb
// Drives voxel colors through the variation block under several register
// settings, predicts each varied color in the testbench and compares it.
// ----------------------------------------------------------------------------

class albedo_scoreboard;
  avhv_pkg::out_item_t pending_colors[$];
  int unsigned         errors;
  int unsigned         checked;

  function void note_voxel(avhv_pkg::out_item_t want);
    pending_colors.push_back(want);
  endfunction

  function void check_color(avhv_pkg::out_item_t got);
    avhv_pkg::out_item_t want;
    if (pending_colors.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
    end else begin
      want = pending_colors.pop_front();
      checked++;
      if (want.out_red !== got.out_red) begin
        $display("%0t: red mismatch exp %0d got %0d", $time, want.out_red, got.out_red);
        errors++;
      end
      if (want.out_green !== got.out_green) begin
        $display("%0t: green mismatch exp %0d got %0d", $time, want.out_green,
                 got.out_green);
        errors++;
      end
      if (want.out_blue !== got.out_blue) begin
        $display("%0t: blue mismatch exp %0d got %0d", $time, want.out_blue,
                 got.out_blue);
        errors++;
      end
    end
  endfunction
endclass

module voxel_albedo_hsv_variation_tb;
  import avhv_pkg::*;

  localparam int unsigned FRAC_BITS = 14;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  in_item_t    item_i;
  logic        result_valid_o;
  out_item_t   result_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  longint unsigned cycle_count = 0;
  int unsigned     sender_idle_pct;
  int unsigned     voxels_sent;
  int unsigned     configs_done;
  albedo_scoreboard board;

  // shadow of the registers, masked as written
  logic [16:0] sh_master;
  logic [59:0] sh_amps;
  logic [14:0] sh_hue;
  logic [16:0] sh_sat;
  logic [16:0] sh_val;
  logic [16:0] sh_fam;

  voxel_albedo_hsv_variation i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("voxel_albedo_hsv_variation test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) board.check_color(result_o);
  end

  // ---------------- prediction ----------------
  function automatic logic [31:0] avalanche32(logic [31:0] v);
    v = v ^ (v >> 16);
    v = v * MUL_AV1;
    v = v ^ (v >> 15);
    v = v * MUL_AV2;
    v = v ^ (v >> 16);
    return v;
  endfunction

  function automatic longint hash_noise(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                        logic [31:0] key, logic [31:0] salt);
    logic [31:0] h;
    longint unsigned t;
    h = HASH_SEED ^ (key * MUL_KEY);
    h = h ^ (x * MUL_X);
    h = h ^ (y * MUL_Y);
    h = h ^ (z * MUL_Z);
    h = h ^ (salt * MUL_SALT);
    h = avalanche32(h);
    t = longint'(h[23:0]) * 131072 + 8388607;
    return longint'(t / 16777215) - 65536;
  endfunction

  // round half up after shifting right
  function automatic longint round_shift(longint v, int sh);
    longint w;
    w = v + (longint'(1) << (sh - 1));
    return w >>> sh;
  endfunction

  function automatic longint snap_step(longint s, longint stp);
    longint mag;
    longint r;
    mag = (s < 0) ? -s : s;
    r = ((mag + stp / 2) / stp) * stp;
    return (s < 0) ? -r : r;
  endfunction

  function automatic longint blend_q16(longint a, longint b, longint w);
    return a + round_shift((b - a) * w, 16);
  endfunction

  function automatic longint spread_term(longint p, longint spread, longint strength);
    return round_shift(round_shift(p * spread, 16) * strength, 16);
  endfunction

  function automatic logic [14:0] clamp_color(longint v);
    longint lim;
    lim = ((135 << FRAC_BITS) + 50) / 100;
    if (v < 0) v = 0;
    if (v > lim) v = lim;
    return v[14:0];
  endfunction

  function automatic out_item_t predict_color(in_item_t it);
    logic [31:0] salts[3];
    longint r, g, b, master, hs, ss, vs, fs, amp, strength;
    longint painted[3];
    longint own, coarse, fine;
    longint mx, mn, delta, hue, sat, val, num;
    longint sector, frac, p, q, t, rr, gg, bb;
    out_item_t o;
    salts[0] = 32'h68bc21eb;
    salts[1] = 32'h02e5be93;
    salts[2] = 32'h967a889b;
    r = it.color_red;
    g = it.color_green;
    b = it.color_blue;
    master = (sh_master > 65536) ? 65536 : sh_master;
    hs = (sh_hue > 16384) ? 16384 : sh_hue;
    ss = (sh_sat > 65536) ? 65536 : sh_sat;
    vs = (sh_val > 65536) ? 65536 : sh_val;
    fs = (sh_fam > 65536) ? 65536 : sh_fam;
    amp = (it.category < 5) ? longint'((sh_amps >> (12 * it.category)) & 60'hfff) : 0;
    strength = (master * amp + 2047) / 4095;
    if (strength == 0) begin
      o.out_red = clamp_color(r);
      o.out_green = clamp_color(g);
      o.out_blue = clamp_color(b);
      return o;
    end
    for (int i = 0; i < 3; i++) begin
      own = hash_noise(it.voxel_x, it.voxel_y, it.voxel_z, it.volume_key, salts[i]);
      coarse = snap_step(hash_noise(it.voxel_x >>> 2, it.voxel_y >>> 2, it.voxel_z >>> 2,
                                    it.volume_key ^ KEY_COARSE, salts[i]), 32768);
      fine = snap_step(hash_noise(it.voxel_x >>> 1, it.voxel_y >>> 1, it.voxel_z >>> 1,
                                  it.volume_key ^ KEY_FINE, salts[i]), 16384);
      painted[i] = blend_q16(own, blend_q16(coarse, fine, 24904), fs);
    end
    mx = (r > g) ? r : g;
    if (b > mx) mx = b;
    mn = (r < g) ? r : g;
    if (b < mn) mn = b;
    delta = mx - mn;
    hue = 0;
    sat = 0;
    if (delta > 0) begin
      if (mx == r) begin
        num = g - b;
        if (num < 0) num += 6 * delta;
      end else if (mx == g) begin
        num = b - r + 2 * delta;
      end else begin
        num = r - g + 4 * delta;
      end
      hue = ((num * 65536 + 3 * delta) / (6 * delta)) & 16'hffff;
    end
    if (mx > 0) sat = (delta * 65536 + mx / 2) / mx;
    val = mx;
    hue = (hue + spread_term(painted[0], hs, strength)) & 16'hffff;
    sat = round_shift(sat * (65536 + spread_term(painted[1], ss, strength)), 16);
    if (sat < 0) sat = 0;
    if (sat > 65536) sat = 65536;
    val = round_shift(val * (65536 + spread_term(painted[2], vs, strength)), 16);
    if (val < 0) val = 0;
    sector = (hue * 6) >>> 16;
    frac = (hue * 6) & 16'hffff;
    p = round_shift(val * (65536 - sat), 16);
    q = round_shift(val * ((longint'(1) << 32) - frac * sat), 32);
    t = round_shift(val * ((longint'(1) << 32) - (65536 - frac) * sat), 32);
    case (sector)
      0: begin rr = val; gg = t; bb = p; end
      1: begin rr = q; gg = val; bb = p; end
      2: begin rr = p; gg = val; bb = t; end
      3: begin rr = p; gg = q; bb = val; end
      4: begin rr = t; gg = p; bb = val; end
      default: begin rr = val; gg = p; bb = q; end
    endcase
    o.out_red = clamp_color(rr);
    o.out_green = clamp_color(gg);
    o.out_blue = clamp_color(bb);
    return o;
  endfunction

  // ---------------- drivers ----------------
  task automatic write_reg(reg_idx_e idx, logic [63:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 6'(idx) << 3;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MASTER: sh_master = value[16:0];
      REG_AMPS:   sh_amps = value[59:0];
      REG_HUE:    sh_hue = value[14:0];
      REG_SAT:    sh_sat = value[16:0];
      REG_VAL:    sh_val = value[16:0];
      default:    sh_fam = value[16:0];
    endcase
    configs_done++;
  endtask

  task automatic load_setting(logic [63:0] master, logic [63:0] amps, logic [63:0] hue,
                              logic [63:0] sat, logic [63:0] val, logic [63:0] fam);
    write_reg(REG_MASTER, master);
    write_reg(REG_AMPS, amps);
    write_reg(REG_HUE, hue);
    write_reg(REG_SAT, sat);
    write_reg(REG_VAL, val);
    write_reg(REG_FAM, fam);
  endtask

  // hold start high across back-to-back words; drop it only on a gap
  task automatic send_voxel(in_item_t it);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    board.note_voxel(predict_color(it));
    voxels_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (board.pending_colors.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic in_item_t random_voxel();
    in_item_t it;
    int unsigned pick;
    pick = $urandom_range(9);
    it.color_red = (pick == 0) ? 16'(32'($urandom_range(1)) * 16'hffff) : 16'($urandom);
    it.color_green = (pick < 2) ? it.color_red : 16'($urandom);
    it.color_blue = (pick == 2) ? it.color_green : 16'($urandom);
    if (pick == 3) begin
      it.color_red = 16'($urandom_range(16384));
      it.color_green = 16'($urandom_range(16384));
      it.color_blue = 16'($urandom_range(16384));
    end
    it.category = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
    if ($urandom_range(3) == 0) begin
      it.voxel_x = $signed(32'($urandom_range(64))) - 32;
      it.voxel_y = $signed(32'($urandom_range(64))) - 32;
      it.voxel_z = $signed(32'($urandom_range(64))) - 32;
    end else begin
      it.voxel_x = $urandom;
      it.voxel_y = $urandom;
      it.voxel_z = $urandom;
    end
    it.volume_key = $urandom;
    return it;
  endfunction

  task automatic random_phase(int unsigned count, int unsigned idle_pct);
    sender_idle_pct = idle_pct;
    for (int unsigned i = 0; i < count; i++) send_voxel(random_voxel());
    sender_idle_pct = 0;
    wait_drained();
  endtask

  task automatic directed_phase();
    in_item_t it;
    logic [15:0] colors[8][3];
    colors[0] = '{16'h0000, 16'h0000, 16'h0000};
    colors[1] = '{16'hffff, 16'hffff, 16'hffff};
    colors[2] = '{16'h2000, 16'h2000, 16'h2000};
    colors[3] = '{16'h4000, 16'h1000, 16'h0800};
    colors[4] = '{16'h1000, 16'h4000, 16'h0800};
    colors[5] = '{16'h0800, 16'h1000, 16'h4000};
    colors[6] = '{16'h4000, 16'h4000, 16'h1000};
    colors[7] = '{16'h1000, 16'h4000, 16'h4000};
    for (int i = 0; i < 16; i++) begin
      it.color_red = colors[i % 8][0];
      it.color_green = colors[i % 8][1];
      it.color_blue = colors[i % 8][2];
      it.category = 3'(i % 8);
      it.voxel_x = (i % 3 == 0) ? 32'sh8000_0000 : (i % 3 == 1) ? 32'sh7fff_ffff : -1;
      it.voxel_y = (i % 2 == 0) ? -7 : 32'sh7fff_ffff;
      it.voxel_z = (i % 4 == 0) ? 0 : 32'sh8000_0000;
      it.volume_key = (i % 2 == 0) ? 32'hffff_ffff : 32'h0;
      send_voxel(it);
    end
    wait_drained();
  endtask

  initial begin
    board = new();
    sender_idle_pct = 0;
    voxels_sent = 0;
    configs_done = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sh_master = '0;
    sh_amps = '0;
    sh_hue = '0;
    sh_sat = '0;
    sh_val = '0;
    sh_fam = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset values pass the color through
    random_phase(30, 0);
    load_setting(65536, 60'h7ff_fff_800_abc_fff, 16384, 65536, 65536, 32768);
    directed_phase();
    random_phase(400, 0);
    // beyond the legal ranges, clamped by the block
    load_setting(64'h1ffff, 64'hffff_ffff_ffff_ffff, 64'h7fff, 64'h1ffff, 64'h1ffff,
                 64'h1ffff);
    random_phase(400, 67);
    load_setting(1, 60'h001_001_001_001_001, 1, 1, 1, 0);
    random_phase(300, 25);
    for (int k = 0; k < 3; k++) begin
      load_setting($urandom_range(65536), {$urandom, $urandom}, $urandom_range(16384),
                   $urandom_range(65536), $urandom_range(65536), $urandom_range(65536));
      random_phase(260, (k == 1) ? 67 : 0);
    end

    $display("covered %0d voxels and %0d register writes; %0d results compared",
             voxels_sent, configs_done, board.checked);
    if (board.errors == 0 && board.pending_colors.size() == 0) begin
      $display("voxel_albedo_hsv_variation test passed");
    end else begin
      $display("voxel_albedo_hsv_variation test failed");
    end
    $finish;
  end

endmodule
